// ----- src/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, disabled while reset is high.
`define BRPUD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("brpud assertion failed");

// Same check written as antecedent and consequent in one cycle.
`define BRPUD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   `BRPUD_ASSERT(label, clk, rst, (ante) |-> (cons))

// Antecedent in one cycle, consequent in the next.
`define BRPUD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   `BRPUD_ASSERT(label, clk, rst, (ante) |=> (cons))

`endif

// ----- src/brpud_pkg.sv -----
`timescale 1ns / 1ps

package brpud_pkg;

   localparam int CAPACITY    = 1024;
   localparam int MAX_POP     = 64;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int FILL_W      = $clog2(CAPACITY + 1);
   localparam int LEVEL_W     = 11;
   localparam int CNT_W       = 7;
   localparam int BYTE_W      = 8;
   localparam int STOP_W      = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STOP_W-1:0] STOP_COUNT = 2'd0;
   localparam logic [STOP_W-1:0] STOP_DELIM = 2'd1;
   localparam logic [STOP_W-1:0] STOP_EMPTY = 2'd2;
   localparam logic [STOP_W-1:0] STOP_PUSH  = 2'd3;

   typedef struct packed {
      logic              is_pop;
      logic [BYTE_W-1:0] push_byte;
      logic [CNT_W-1:0]  limit;
      logic              den;
      logic [BYTE_W-1:0] delim;
   } cmd_type;

   typedef struct packed {
      logic               push_accepted;
      logic [BYTE_W-1:0]  byte_out;
      logic               has_byte;
      logic               last;
      logic [CNT_W-1:0]   popped_count;
      logic [STOP_W-1:0]  stop_reason;
      logic [LEVEL_W-1:0] fill_level;
   } rsp_type;

   function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p);
      return (p == ADDR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

// ----- src/brpud_ram.sv -----
`timescale 1ns / 1ps

module brpud_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/brpud_front.sv -----
`timescale 1ns / 1ps

module brpud_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [brpud_pkg::BYTE_W-1:0]  req_push_byte,
   input  logic [brpud_pkg::CNT_W-1:0]   req_max_count,
   input  logic                          req_delimiter_enable,
   input  logic [brpud_pkg::BYTE_W-1:0]  req_delimiter,
   output logic                          cmd_valid,
   output brpud_pkg::cmd_type            cmd,
   input  logic                          cmd_take
);
   import brpud_pkg::*;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              accept;
   cmd_type           cls;

   // Classify: pop count saturates at MAX_POP.
   always_comb begin
      cls.is_pop    = (req_operation == OP_POP);
      cls.push_byte = req_push_byte;
      cls.limit     = (req_max_count > CNT_W'(MAX_POP)) ? CNT_W'(MAX_POP) : req_max_count;
      cls.den       = req_delimiter_enable;
      cls.delim     = req_delimiter;
   end

   assign busy      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = start && !busy;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (cmd_take) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (accept && !cmd_take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!accept && cmd_take) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wptr_ff] <= cls;
      end
   end

endmodule

// ----- src/brpud_back.sv -----
`timescale 1ns / 1ps

module brpud_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  brpud_pkg::cmd_type cmd,
   output logic               cmd_take,
   output logic               rsp_valid,
   output brpud_pkg::rsp_type rsp
);
   import brpud_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   logic              state_ff, state_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   cmd_type           cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              full;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;
   logic [FILL_W-1:0] fill_dec;
   logic [CNT_W-1:0]  cnt_inc;
   logic              delim_hit, count_hit, empty_hit;

   // Read ahead: in POP the RAM already fetches the byte after the current one.
   assign ram_raddr = (state_ff == ST_POP) ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
   assign full      = (fill_ff == FILL_W'(CAPACITY));
   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid;
   assign ram_we    = cmd_take && !cmd.is_pop && !full;

   brpud_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_ptr_ff),
      .wdata (cmd.push_byte),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign fill_dec  = fill_ff - 1'b1;
   assign cnt_inc   = cnt_ff + 1'b1;
   assign delim_hit = cur_ff.den && (ram_rdata == cur_ff.delim);
   assign count_hit = (cnt_inc == cur_ff.limit);
   assign empty_hit = (fill_dec == '0);

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               rsp_in.push_accepted = 1'b0;
               rsp_in.byte_out      = '0;
               rsp_in.has_byte      = 1'b0;
               rsp_in.last          = 1'b1;
               rsp_in.popped_count  = '0;
               rsp_in.fill_level    = LEVEL_W'(fill_ff);
               if (!cmd.is_pop) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.stop_reason = STOP_PUSH;
                  if (!full) begin
                     rsp_in.push_accepted = 1'b1;
                     rsp_in.fill_level    = LEVEL_W'(fill_ff + 1'b1);
                     fill_in              = fill_ff + 1'b1;
                     wr_ptr_in            = ptr_next(wr_ptr_ff);
                  end
               end else if (cmd.limit == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.stop_reason = STOP_COUNT;
               end else if (fill_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.stop_reason = STOP_EMPTY;
               end else begin
                  state_in = ST_POP;
                  cnt_in   = '0;
                  cur_in   = cmd;
               end
            end
         end
         ST_POP: begin
            rsp_valid_in         = 1'b1;
            rsp_in.push_accepted = 1'b0;
            rsp_in.byte_out      = ram_rdata;
            rsp_in.has_byte      = 1'b1;
            rsp_in.last          = delim_hit || count_hit || empty_hit;
            rsp_in.popped_count  = cnt_inc;
            rsp_in.fill_level    = LEVEL_W'(fill_dec);
            if (delim_hit) begin
               rsp_in.stop_reason = STOP_DELIM;
            end else if (count_hit) begin
               rsp_in.stop_reason = STOP_COUNT;
            end else if (empty_hit) begin
               rsp_in.stop_reason = STOP_EMPTY;
            end else begin
               rsp_in.stop_reason = STOP_COUNT;
            end
            rd_ptr_in = ptr_next(rd_ptr_ff);
            fill_in   = fill_dec;
            cnt_in    = cnt_inc;
            if (rsp_in.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- src/byte_ring_pop_until_delimiter.sv -----
`timescale 1ns / 1ps

// Circular byte queue (1024 bytes) with pop-until-delimiter reads.
// Input: an item is taken at a clock edge with start high and busy low.
//   req_operation 0 pushes req_push_byte; 1 pops up to req_max_count bytes
//   (saturated at 64), stopping after req_delimiter when req_delimiter_enable.
// Output: each result sits on the rsp_ ports for one cycle with rsp_valid
//   high. The receiver cannot stall; results come out back to back.
// Results: a push or a pop that removes nothing gives one result, taken
//   from the queue and registered by the executor in IDLE. A pop of n bytes
//   is taken in IDLE, then gives one byte per cycle in POP, its first after
//   the RAM read; rsp_last marks the final one. The rate is set by the single
//   RAM read port with one-ahead prefetch; no new command is taken until the
//   pop ends. A two-entry command queue sits between the front and the
//   executor; busy is high while it is full.
// Reset (synchronous, active high) empties the queue and pointers; the byte
//   store itself is not cleared, nothing unwritten is ever read.
module byte_ring_pop_until_delimiter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [brpud_pkg::BYTE_W-1:0]  req_push_byte,
   input  logic [brpud_pkg::CNT_W-1:0]   req_max_count,
   input  logic                          req_delimiter_enable,
   input  logic [brpud_pkg::BYTE_W-1:0]  req_delimiter,
   output logic                          rsp_valid,
   output logic                          rsp_push_accepted,
   output logic [brpud_pkg::BYTE_W-1:0]  rsp_byte_out,
   output logic                          rsp_has_byte,
   output logic                          rsp_last,
   output logic [brpud_pkg::CNT_W-1:0]   rsp_popped_count,
   output logic [brpud_pkg::STOP_W-1:0]  rsp_stop_reason,
   output logic [brpud_pkg::LEVEL_W-1:0] rsp_fill_level
);
   import brpud_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   rsp_type rsp;

   // Front: classify each item and queue it.
   brpud_front u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_push_byte        (req_push_byte),
      .req_max_count        (req_max_count),
      .req_delimiter_enable (req_delimiter_enable),
      .req_delimiter        (req_delimiter),
      .cmd_valid            (cmd_valid),
      .cmd                  (cmd),
      .cmd_take             (cmd_take)
   );

   // Back: owns the byte store, pointers and fill count.
   brpud_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_push_accepted = rsp.push_accepted;
   assign rsp_byte_out      = rsp.byte_out;
   assign rsp_has_byte      = rsp.has_byte;
   assign rsp_last          = rsp.last;
   assign rsp_popped_count  = rsp.popped_count;
   assign rsp_stop_reason   = rsp.stop_reason;
   assign rsp_fill_level    = rsp.fill_level;

endmodule

// ----- src/brpud_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brpud_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_push_accepted,
   input logic                          rsp_has_byte,
   input logic                          rsp_last,
   input logic [brpud_pkg::CNT_W-1:0]   rsp_popped_count,
   input logic [brpud_pkg::STOP_W-1:0]  rsp_stop_reason,
   input logic [brpud_pkg::LEVEL_W-1:0] rsp_fill_level
);
   import brpud_pkg::*;

   logic             byte_rsp;
   logic             push_rsp;
   logic             open_rsp;
   logic             drain_rsp;
   logic             byte_counted;
   logic [CNT_W-1:0] next_cnt_ff, next_cnt_in;

   assign byte_rsp     = rsp_valid && rsp_has_byte;
   assign push_rsp     = rsp_valid && (rsp_stop_reason == STOP_PUSH);
   assign open_rsp     = rsp_valid && !rsp_last;
   assign drain_rsp    = byte_rsp && (rsp_stop_reason == STOP_EMPTY);
   assign byte_counted = !rsp_push_accepted && (rsp_popped_count != '0);
   assign next_cnt_in  = rsp_popped_count + 1'b1;

   always_ff @(posedge clock) begin
      next_cnt_ff <= next_cnt_in;
   end

   // A byte result comes from a pop and counts itself.
   `BRPUD_ASSERT_IMPL(a_byte_is_pop, clock, reset, byte_rsp, byte_counted)
   // Push results are single, last and byteless.
   `BRPUD_ASSERT_IMPL(a_push_single, clock, reset, push_rsp, rsp_last && !rsp_has_byte)
   // A pop that has not ended is followed at once by its next byte.
   `BRPUD_ASSERT_NEXT(a_pop_next, clock, reset, open_rsp, byte_rsp && rsp_popped_count == next_cnt_ff)
   // Drained mid-pop means the level reads zero.
   `BRPUD_ASSERT_IMPL(a_drain_level, clock, reset, drain_rsp, rsp_fill_level == '0)

endmodule

bind byte_ring_pop_until_delimiter brpud_checker u_checker (.*);
